// File: rtl/core/lfcp_pkg.sv
// Shared constants, types and helper functions of the lidar frame parser.
package lfcp_pkg;

    localparam int FRAME_BYTES = 47;
    localparam int CRC_BYTES   = FRAME_BYTES - 1;
    localparam int POINTS      = 12;
    localparam int DIST_BASE   = 6;
    localparam int DIST_STRIDE = 3;
    localparam int POS_TEMP    = 2;
    localparam int POS_START   = 4;
    localparam int POS_END     = 42;
    localparam int POS_TIME    = 44;

    localparam int WIN_AW    = 6;
    localparam int WIN_DEPTH = 1 << WIN_AW;
    localparam int FILL_W    = 6;
    localparam int SUM_W     = 20;
    localparam int CNT_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CRC_POLY      = 8'h4D;
    localparam logic [7:0] HEADER_RESET  = 8'd84;
    localparam logic [7:0] VERSION_RESET = 8'd44;

    localparam logic [7:0] CFG_HEADER  = 8'd0;
    localparam logic [7:0] CFG_VERSION = 8'd1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } lfcp_item_t;

    typedef struct packed {
        logic [15:0] mean_distance;
        logic [3:0]  valid_points;
        logic [15:0] scan_begin_angle;
        logic [15:0] scan_stop_angle;
        logic [15:0] sensor_temperature;
        logic [15:0] frame_time;
        logic [15:0] frame_count;
    } lfcp_result_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic is_point_low(input logic [FILL_W-1:0] idx);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < POINTS; k++) begin
            if (idx == FILL_W'(DIST_BASE + DIST_STRIDE * k))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic is_point_high(input logic [FILL_W-1:0] idx);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < POINTS; k++) begin
            if (idx == FILL_W'(DIST_BASE + DIST_STRIDE * k + 1))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// File: rtl/core/lidar_frame_crc8_parser_core.sv
// Top level of the lidar frame parser: configuration registers, word queue and frame engine.
// A word that completes a 47-byte window with a matching header and version byte adds a CRC
// pass over the window memory (one byte read per cycle). A good frame then runs the mean
// division when any point is nonzero and posts the result; a failed check drops the header
// byte and rescans the remaining bytes. A two-word queue in front lets the link side keep
// delivering while a word is worked on, and the result register lets the next word proceed
// while a result waits; a second good frame stalls until the waiting result is taken.
// Configuration writes are accepted every cycle.
module lidar_frame_crc8_parser_core
    import lfcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        burst_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] mean_distance,
    output logic [3:0]  valid_points,
    output logic [15:0] scan_begin_angle,
    output logic [15:0] scan_stop_angle,
    output logic [15:0] sensor_temperature,
    output logic [15:0] frame_time,
    output logic [15:0] frame_count
);

    logic [7:0]   header_reg;
    logic [7:0]   version_reg;
    lfcp_item_t   in_item;
    lfcp_item_t   q_item;
    logic         q_valid;
    logic         q_ready;
    lfcp_result_t result;

    assign cfg_ready    = 1'b1;
    assign in_item.data = data_byte;
    assign in_item.last = burst_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= HEADER_RESET;
            version_reg <= VERSION_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HEADER:  header_reg  <= cfg_data;
                CFG_VERSION: version_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    lfcp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    lfcp_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .header_byte  (header_reg),
        .version_byte (version_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_result   (result)
    );

    assign mean_distance      = result.mean_distance;
    assign valid_points       = result.valid_points;
    assign scan_begin_angle   = result.scan_begin_angle;
    assign scan_stop_angle    = result.scan_stop_angle;
    assign sensor_temperature = result.sensor_temperature;
    assign frame_time         = result.frame_time;
    assign frame_count        = result.frame_count;

endmodule

// File: rtl/core/lfcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/lfcp_fifo.sv
// Front queue that takes received words and hands them to the frame engine.
module lfcp_fifo
    import lfcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lfcp_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output lfcp_item_t out_item
);

    lfcp_item_t entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'(QUEUE_DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

endmodule

// File: rtl/core/lfcp_div.sv
// Restoring divider, one quotient bit per cycle, for the mean distance.
module lfcp_div
    import lfcp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    logic [SUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] div_reg;
    logic [4:0]       step_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W:0]   trial;
    logic             fits;

    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= CNT_W'(trial - {1'b0, div_reg});
                end
                else
                begin
                    rem_reg <= trial[CNT_W-1:0];
                end
                quo_reg  <= {quo_reg[SUM_W-2:0], fits};
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/core/lfcp_engine.sv
// Back end: frame window, header search, CRC check, field capture and result register.
module lfcp_engine
    import lfcp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   header_byte,
    input  logic [7:0]   version_byte,
    input  logic         q_valid,
    output logic         q_ready,
    input  lfcp_item_t   q_item,
    output logic         out_valid,
    input  logic         out_ready,
    output lfcp_result_t out_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_HDR,
        S_VER,
        S_CRC,
        S_DIV,
        S_EMIT,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic [WIN_AW-1:0]   head_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   idx_reg;
    logic [7:0]          crc_reg;
    logic [7:0]          lo_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [15:0]         temp_reg;
    logic [15:0]         start_reg;
    logic [15:0]         end_reg;
    logic [15:0]         time_reg;
    logic [15:0]         held_reg;
    logic [15:0]         frames_reg;
    logic                last_reg;
    logic                out_valid_reg;
    lfcp_result_t        result_reg;
    logic                div_start_reg;

    logic                win_we;
    logic [WIN_AW-1:0]   win_waddr;
    logic [WIN_AW-1:0]   win_raddr;
    logic [7:0]          win_rdata;
    logic                div_done;
    logic [SUM_W-1:0]    div_quotient;
    logic [15:0]         pt_dist;
    logic                window_full;
    logic                emit_fire;

    assign q_ready     = (state_reg == S_IDLE);
    assign window_full = (fill_reg == FILL_W'(FRAME_BYTES));
    assign win_we      = (state_reg == S_IDLE) && q_valid && !window_full;
    assign win_waddr   = head_reg + WIN_AW'(fill_reg);
    assign pt_dist     = {win_rdata, lo_reg};
    assign emit_fire   = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign out_result  = result_reg;

    always_comb
    begin
        unique case (state_reg)
            S_HDR:   win_raddr = head_reg + WIN_AW'(1);
            S_CRC:   win_raddr = head_reg + WIN_AW'(idx_reg) + WIN_AW'(1);
            default: win_raddr = head_reg;
        endcase
    end

    lfcp_ram #(
        .WIDTH (8),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (q_item.data),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    lfcp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            crc_reg       <= '0;
            lo_reg        <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            temp_reg      <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            time_reg      <= '0;
            held_reg      <= '0;
            frames_reg    <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (!window_full)
                        begin
                            fill_reg <= fill_reg + FILL_W'(1);
                        end
                        last_reg  <= q_item.last;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (fill_reg == '0)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_HDR;
                    end
                end
                S_HDR:
                begin
                    if (win_rdata != header_byte)
                    begin
                        head_reg  <= head_reg + WIN_AW'(1);
                        fill_reg  <= fill_reg - FILL_W'(1);
                        state_reg <= S_CHECK;
                    end
                    else if (fill_reg < FILL_W'(2))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_VER;
                    end
                end
                S_VER:
                begin
                    if (win_rdata != version_byte)
                    begin
                        head_reg  <= head_reg + WIN_AW'(1);
                        fill_reg  <= fill_reg - FILL_W'(1);
                        state_reg <= S_CHECK;
                    end
                    else if (!window_full)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        crc_reg   <= '0;
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_CRC;
                    end
                end
                S_CRC:
                begin
                    if (idx_reg != FILL_W'(CRC_BYTES))
                    begin
                        crc_reg <= crc8_step(crc_reg, win_rdata);
                        idx_reg <= idx_reg + FILL_W'(1);
                        case (idx_reg)
                            FILL_W'(POS_TEMP):      temp_reg[7:0]   <= win_rdata;
                            FILL_W'(POS_TEMP + 1):  temp_reg[15:8]  <= win_rdata;
                            FILL_W'(POS_START):     start_reg[7:0]  <= win_rdata;
                            FILL_W'(POS_START + 1): start_reg[15:8] <= win_rdata;
                            FILL_W'(POS_END):       end_reg[7:0]    <= win_rdata;
                            FILL_W'(POS_END + 1):   end_reg[15:8]   <= win_rdata;
                            FILL_W'(POS_TIME):      time_reg[7:0]   <= win_rdata;
                            FILL_W'(POS_TIME + 1):  time_reg[15:8]  <= win_rdata;
                            default:                ;
                        endcase
                        if (is_point_low(idx_reg))
                        begin
                            lo_reg <= win_rdata;
                        end
                        if (is_point_high(idx_reg) && (pt_dist != '0))
                        begin
                            sum_reg <= sum_reg + SUM_W'(pt_dist);
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (crc_reg == win_rdata)
                    begin
                        if (cnt_reg != '0)
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        head_reg  <= head_reg + WIN_AW'(1);
                        fill_reg  <= fill_reg - FILL_W'(1);
                        state_reg <= S_CHECK;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        held_reg  <= div_quotient[15:0];
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        result_reg.mean_distance      <= held_reg;
                        result_reg.valid_points       <= cnt_reg;
                        result_reg.scan_begin_angle   <= start_reg;
                        result_reg.scan_stop_angle    <= end_reg;
                        result_reg.sensor_temperature <= temp_reg;
                        result_reg.frame_time         <= time_reg;
                        result_reg.frame_count        <= frames_reg + 16'd1;
                        frames_reg    <= frames_reg + 16'd1;
                        fill_reg      <= '0;
                        state_reg     <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (last_reg)
                    begin
                        fill_reg <= '0;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(FRAME_BYTES))
        else $error("Window fill exceeds the frame length.");

    a_crc_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRC) |-> window_full)
        else $error("CRC pass running on a window that is not full.");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("Divider finished outside the divide state.");

endmodule
